[hdl/spq_pkg.sv]
// Shared types and constants for the sorted-insert priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] chr;
  } entry_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cell_ctl_t;

endpackage

[hdl/sorted_insert_priority_queue_core.sv]
// Priority queue of up to DEPTH (priority, character) entries, smallest priority first,
// equal priorities in arrival order. Each transaction is an enqueue or a dequeue and gives
// exactly one result. Depends on spq_pkg and spq_cell.
//
// The queue is a row of DEPTH cells kept in sorted order; every cell compares its own
// entry with the incoming one in parallel, so an insert or a removal updates all cells
// together. One transaction is accepted per cycle; the result appears in the output register
// the cycle after acceptance, and a new transaction is taken while that result waits as
// long as the result is being taken in the same cycle. Rejected operations (enqueue on
// full, dequeue on empty) leave the queue unchanged and report it in status.
module sorted_insert_priority_queue_core import spq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [7:0] item_priority, [15:8] item_char
  input  logic        in_tuser,    // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata    // [7:0] out_char, [15:8] out_priority, [17:16] status,
                                   // [22:18] entry_count, [23] is_empty, [24] is_full
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [24:0]      out_data_r, out_data_nxt;

  logic      accept, is_enq, full, empty;
  cell_ctl_t ctl;
  entry_t    item;
  status_t   status;
  entry_t    res;

  logic   cell_le  [DEPTH];
  entry_t cell_ent [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_enq    = (opcode_t'(in_tuser) == OP_ENQ);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  assign item.prio = in_tdata[7:0];
  assign item.chr  = in_tdata[15:8];

  assign ctl.enq  = accept && is_enq && !full;
  assign ctl.deq  = accept && !is_enq && !empty;
  assign ctl.item = item;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic   occ;
    logic   l_le;
    entry_t l_ent, r_ent;

    assign occ = (count_r > CNT_W'(k));

    if (k == 0) begin : g_head
      assign l_le  = 1'b1;
      assign l_ent = item;
    end else begin : g_body
      assign l_le  = cell_le[k-1];
      assign l_ent = cell_ent[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign r_ent = cell_ent[k];
    end else begin : g_mid
      assign r_ent = cell_ent[k+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ),
      .left_le     (l_le),
      .left_entry  (l_ent),
      .right_entry (r_ent),
      .le          (cell_le[k]),
      .entry       (cell_ent[k])
    );
  end

  always_comb begin
    count_nxt = count_r;
    res       = '0;
    status    = ST_DONE;
    if (ctl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.deq) begin
      count_nxt = count_r - CNT_W'(1);
      res       = cell_ent[0];
    end else if (is_enq) begin
      status = ST_FULL;
    end else begin
      status = ST_EMPTY;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {(count_nxt == CNT_W'(DEPTH)), (count_nxt == '0),
                       5'(count_nxt), status, res.prio, res.chr};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("stored count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted transaction produced no result");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.enq |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("enqueue did not grow the count");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > CNT_W'(1)) |-> (cell_ent[0].prio <= cell_ent[1].prio))
    else $error("head entries out of order");

endmodule

[hdl/spq_cell.sv]
// One slot of the sorted chain: holds an entry, compares it with the incoming one.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,          // slot lies below the stored count
  input  logic      left_le,      // left neighbor keeps its entry on insert
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output logic      le,
  output entry_t    entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  assign le    = occ && (entry_r.prio <= ctl.item.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.enq) begin
      // first slot that does not keep takes the new entry, the rest shift right
      if (!le) begin
        entry_nxt = left_le ? ctl.item : left_entry;
      end
    end else if (ctl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[test/tb_top.sv]
// Self-checking testbench for sorted_insert_priority_queue_core: directed and random
// enqueue/dequeue traffic against a sorted-array predictor, with bursty input and a stalling
// receiver. Depends on spq_pkg and the core RTL.
module tb_top;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    opcode_t    op;
    logic [7:0] prio;
    logic [7:0] chr;
  } queue_op_t;

  typedef struct packed {
    logic [7:0] chr;
    logic [7:0] prio;
    status_t    status;
    logic [4:0] count;
    logic       empty;
    logic       full;
  } queue_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] item_priority, [15:8] item_char
  logic        in_tuser = 1'b0; // [0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [7:0] out_char, [15:8] out_priority, [17:16] status,
                                // [22:18] entry_count, [23] is_empty, [24] is_full

  queue_op_t   pending_ops[$];
  queue_resp_t expected_resps[$];

  // predictor state
  logic [7:0] model_prio[DEPTH];
  logic [7:0] model_chr[DEPTH];
  int         model_count = 0;

  int errors = 0;
  int burst_left = 1;
  int gap_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  sorted_insert_priority_queue_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the sorted-array model and queue the response it must give.
  task automatic predict_queue_op(input queue_op_t op);
    queue_resp_t r;
    int pos;
    int k;
    r = '0;
    r.status = ST_DONE;
    if (op.op == OP_ENQ) begin
      if (model_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        // ties go behind existing entries of the same priority
        while (pos < model_count && model_prio[pos] <= op.prio) pos++;
        for (k = model_count; k > pos; k--) begin
          model_prio[k] = model_prio[k-1];
          model_chr[k]  = model_chr[k-1];
        end
        model_prio[pos] = op.prio;
        model_chr[pos]  = op.chr;
        model_count++;
      end
    end else if (model_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.prio = model_prio[0];
      r.chr  = model_chr[0];
      for (k = 1; k < model_count; k++) begin
        model_prio[k-1] = model_prio[k];
        model_chr[k-1]  = model_chr[k];
      end
      model_count--;
    end
    r.count = model_count[4:0];
    r.empty = (model_count == 0);
    r.full  = (model_count >= DEPTH);
    expected_resps.push_back(r);
  endtask

  // Driver: bursts of back-to-back transactions separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_queue_op(pending_ops[0]);
        void'(pending_ops.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered transaction
      end else if (gap_left > 0 || pending_ops.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= {pending_ops[0].chr, pending_ops[0].prio};
        in_tuser  <= pending_ops[0].op;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: randomly re-chosen stall pattern, plus two long hold-offs.
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (rx_cycle == 500 || rx_cycle == 1200) hold_left = 150;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: out_tready <= (rx_cycle % 4 == 0);
        default: out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Monitor
  always @(posedge clk) begin
    queue_resp_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_resps.size() == 0) begin
        $error("unexpected result transaction: tdata=%h", out_tdata);
        errors++;
      end else begin
        exp_r = expected_resps.pop_front();
        if (out_tdata[7:0] !== exp_r.chr) begin
          $error("out_char: expected %0d, actual %0d", exp_r.chr, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[15:8] !== exp_r.prio) begin
          $error("out_priority: expected %0d, actual %0d", exp_r.prio, out_tdata[15:8]);
          errors++;
        end
        if (out_tdata[17:16] !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_tdata[17:16]);
          errors++;
        end
        if (out_tdata[22:18] !== exp_r.count) begin
          $error("entry_count: expected %0d, actual %0d", exp_r.count, out_tdata[22:18]);
          errors++;
        end
        if (out_tdata[23] !== exp_r.empty) begin
          $error("is_empty: expected %0d, actual %0d", exp_r.empty, out_tdata[23]);
          errors++;
        end
        if (out_tdata[24] !== exp_r.full) begin
          $error("is_full: expected %0d, actual %0d", exp_r.full, out_tdata[24]);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    queue_op_t op;
    int enq_pct;
    int prio_mode;
    int k;
    logic [7:0] fill_prio[16];
    fill_prio = '{8'd255, 8'd0, 8'd0, 8'd128, 8'd255, 8'd1, 8'd128, 8'd0,
                  8'd254, 8'd7, 8'd7, 8'd7, 8'd200, 8'd3, 8'd255, 8'd0};

    // Directed: dequeue on empty, fill with ties and extremes, enqueue on full, drain some.
    op = '{OP_DEQ, 8'hFF, 8'hFF};
    pending_ops.push_back(op);
    for (k = 0; k < DEPTH; k++) begin
      op = '{OP_ENQ, fill_prio[k % 16], 8'(k * 17)};
      pending_ops.push_back(op);
    end
    op = '{OP_ENQ, 8'h00, 8'h5A};
    pending_ops.push_back(op);
    for (k = 0; k < 6; k++) begin
      op = '{OP_DEQ, 8'(k), 8'(255 - k)};
      pending_ops.push_back(op);
    end

    // Random segments with a varying enqueue/dequeue mix to sweep between empty and full.
    enq_pct = 50;
    prio_mode = 0;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 32 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 20;
          1: enq_pct = 50;
          2: enq_pct = 80;
          default: enq_pct = 95;
        endcase
        prio_mode = $urandom_range(0, 3);
      end
      op.op  = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
      op.chr = 8'($urandom_range(0, 255));
      case (prio_mode)
        0: op.prio = 8'($urandom_range(0, 255));
        1: op.prio = 8'($urandom_range(0, 3));      // dense ties
        2: op.prio = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
        default: op.prio = 8'($urandom_range(100, 103));
      endcase
      pending_ops.push_back(op);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || expected_resps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_insert_priority_queue_core.sv
test/tb_top.sv
